// ===== hdl/smmt_pkg.sv =====
// Shared constants and types for the shape measurement merge table.
`default_nettype none
package smmt_pkg;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int SPH_COMP        = 4;
    localparam int CYL_COMP        = 7;
    localparam int COMP_W          = 3;
    localparam logic [30:0] MATCH_DIST_RST = 31'd3277;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [63:0] DIST_SAT  = 64'h4000_0000_0000_0000;

    // Divider request/response between sequencer and divider.
    typedef struct packed {
        logic        start;
        logic [33:0] num;
        logic [16:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [33:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/smmt_div.sv =====
// Radix-2 restoring divider: floor of signed numerator by positive denominator.
`default_nettype none
module smmt_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire smmt_pkg::div_req_t req,
    output smmt_pkg::div_rsp_t     rsp
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic [33:0] q_reg, q_next;
    logic [17:0] r_reg, r_next;
    logic [16:0] d_reg, d_next;
    logic        done_reg, done_next;
    logic [33:0] mag;
    logic [17:0] trial;
    logic [34:0] fq;

    // Negative numerators: floor(n/d) = -ceil(|n|/d) = -((|n|+d-1)/d).
    assign mag = req.num[33] ? (34'(-req.num) + 34'(req.den) - 34'd1) : req.num;
    assign trial = {r_reg[16:0], q_reg[33]} - {1'b0, d_reg};
    assign fq = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};

    always_comb begin
        cnt_next = cnt_reg; busy_next = busy_reg; neg_next = neg_reg;
        q_next = q_reg; r_next = r_reg; d_next = d_reg; done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1; cnt_next = 6'd34; neg_next = req.num[33];
            q_next = mag; r_next = '0; d_next = req.den;
        end else if (busy_reg) begin
            if (!trial[17]) begin
                r_next = trial; q_next = {q_reg[32:0], 1'b1};
            end else begin
                r_next = {r_reg[16:0], q_reg[33]}; q_next = {q_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
        neg_reg <= neg_next; q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = fq[33:0];
endmodule
`default_nettype wire

// ===== hdl/shape_measurement_merge_table.sv =====
// Top level: sphere and cylinder merge tables with running-mean update.
`default_nettype none
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    kind, frame_start, val0..val6
// m_        out        m_valid / m_ready    slot, is_new, table_full, mean0..mean6
// cfg       in         cfg_we               cfg_wdata (match distance)
//
// One request in flight; s_ready is high only while the sequencer is idle.
// Scan: per component a read, a settle and an accumulate state, plus one decision per entry
// and variant; a cylinder entry is scanned for both axes.
// Merge per component: read, start, 34-step divide, write back.
// Reset is synchronous active low, clears table fill counts and control state.
// A finished result moves to the output register; the sequencer waits in its
// last state only while the previous result is still held there.
module shape_measurement_merge_table #(
    parameter int MAX_ENTRIES = smmt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [30:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic        s_frame_start,
    input  wire logic signed [31:0] s_val0,
    input  wire logic signed [31:0] s_val1,
    input  wire logic signed [31:0] s_val2,
    input  wire logic signed [31:0] s_val3,
    input  wire logic signed [31:0] s_val4,
    input  wire logic signed [31:0] s_val5,
    input  wire logic signed [31:0] s_val6,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_slot,
    output logic             m_is_new,
    output logic             m_table_full,
    output logic signed [31:0] m_mean0,
    output logic signed [31:0] m_mean1,
    output logic signed [31:0] m_mean2,
    output logic signed [31:0] m_mean3,
    output logic signed [31:0] m_mean4,
    output logic signed [31:0] m_mean5,
    output logic signed [31:0] m_mean6
);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int UW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = smmt_pkg::COMP_W;
    localparam int SD = MAX_ENTRIES * smmt_pkg::SPH_COMP;
    localparam int CD = MAX_ENTRIES * smmt_pkg::CYL_COMP;
    localparam int SAW = $clog2(SD);
    localparam int CAW = $clog2(CD);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_ACC   = 4'd3;
    localparam logic [3:0] ST_DEC   = 4'd4;
    localparam logic [3:0] ST_DRD   = 4'd5;
    localparam logic [3:0] ST_DSTART= 4'd6;
    localparam logic [3:0] ST_DWAIT = 4'd7;
    localparam logic [3:0] ST_NEW   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;
    localparam logic [3:0] ST_RDW   = 4'd10;
    localparam logic [3:0] ST_DRDW  = 4'd11;

    logic [3:0] st_reg, st_next;
    logic [30:0] md_reg;
    logic [UW-1:0] sph_used_reg, cyl_used_reg;
    logic cyl_reg;
    logic signed [31:0] m_reg [smmt_pkg::CYL_COMP];
    logic [IW-1:0] ent_reg;
    logic var_reg;
    logic [CW-1:0] comp_reg;
    logic [63:0] acc_reg;
    logic far_reg;
    logic [15:0] n_reg;
    logic signed [31:0] res_reg [smmt_pkg::CYL_COMP];
    logic [3:0] slot_reg;
    logic new_reg, full_reg, ovalid_reg;
    // Output register, parts the finished result from the working registers.
    logic [3:0] out_slot_reg;
    logic out_new_reg, out_full_reg;
    logic signed [31:0] out_mean_reg [smmt_pkg::CYL_COMP];
    logic out_free;

    logic signed [31:0] smem [SD];
    logic signed [31:0] cmem [CD];
    logic [15:0] scnt [MAX_ENTRIES];
    logic [15:0] ccnt [MAX_ENTRIES];
    logic signed [31:0] rd_reg;
    logic [15:0] cnt_rd_reg;

    logic [2:0] nc;
    logic [UW-1:0] used;
    logic [SAW-1:0] saddr;
    logic [CAW-1:0] caddr;
    logic signed [31:0] mv;
    logic signed [32:0] d33;
    logic [32:0] ad;
    logic [63:0] sq;
    logic [64:0] acc_sum;
    logic last_comp;
    logic we_mem;
    logic signed [31:0] wdata;
    smmt_pkg::div_req_t dreq;
    smmt_pkg::div_rsp_t drsp;
    logic signed [31:0] blended;
    logic [15:0] n_inc;

    assign nc = cyl_reg ? 3'(smmt_pkg::CYL_COMP) : 3'(smmt_pkg::SPH_COMP);
    assign used = cyl_reg ? cyl_used_reg : sph_used_reg;
    assign last_comp = ({1'b0, comp_reg} == 4'(nc) - 4'd1);
    assign saddr = SAW'(ent_reg * smmt_pkg::SPH_COMP + comp_reg);
    assign caddr = CAW'(ent_reg * smmt_pkg::CYL_COMP + comp_reg);
    assign out_free = !ovalid_reg || m_ready;

    // Component value of the selected variant (axis negated, saturated).
    always_comb begin
        mv = m_reg[comp_reg];
        if (var_reg && comp_reg >= CW'(3) && comp_reg <= CW'(5))
            mv = (m_reg[comp_reg] == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -m_reg[comp_reg];
    end

    assign d33 = 33'(mv) - 33'(rd_reg);
    assign ad  = d33[32] ? 33'(-d33) : d33;
    assign sq  = 64'(ad[31:0]) * 64'(ad[31:0]);
    assign acc_sum = {1'b0, acc_reg} + {1'b0, sq};

    assign n_inc = (cnt_rd_reg == smmt_pkg::COUNT_MAX) ? cnt_rd_reg : cnt_rd_reg + 16'd1;
    assign dreq.start = (st_reg == ST_DSTART);
    assign dreq.num = 34'(d33) + 34'(d33) + 34'(n_reg);
    assign dreq.den = {n_reg, 1'b0};
    assign blended = rd_reg + drsp.quo[31:0];

    smmt_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign we_mem = (st_reg == ST_NEW) || (st_reg == ST_DWAIT && drsp.done);
    assign wdata  = (st_reg == ST_NEW) ? m_reg[comp_reg] : blended;

    always_ff @(posedge aclk) begin
        if (cyl_reg) begin
            if (we_mem) cmem[caddr] <= wdata;
            rd_reg <= cmem[caddr];
            cnt_rd_reg <= ccnt[ent_reg];
        end else begin
            if (we_mem) smem[saddr] <= wdata;
            rd_reg <= smem[saddr];
            cnt_rd_reg <= scnt[ent_reg];
        end
        if (st_reg == ST_NEW && comp_reg == '0) begin
            if (cyl_reg) ccnt[ent_reg] <= 16'd1; else scnt[ent_reg] <= 16'd1;
        end
        if (st_reg == ST_DEC && !far_reg && acc_reg < 64'(md_reg) * 64'(md_reg)) begin
            if (cyl_reg) ccnt[ent_reg] <= n_inc; else scnt[ent_reg] <= n_inc;
        end
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:   if (s_valid) st_next = ST_PREP;
            ST_PREP:   st_next = (used == '0) ? ST_NEW : ST_RDW;
            ST_RDW:    st_next = ST_RD;
            ST_RD:     st_next = ST_ACC;
            ST_ACC:    st_next = last_comp ? ST_DEC : ST_RDW;
            ST_DEC:    begin
                if (!far_reg && acc_reg < 64'(md_reg) * 64'(md_reg)) st_next = ST_DRDW;
                else if (cyl_reg && !var_reg) st_next = ST_RDW;
                else if (UW'(ent_reg) + UW'(1) < used) st_next = ST_RDW;
                else if (used < UW'(MAX_ENTRIES)) st_next = ST_NEW;
                else st_next = ST_OUT;
            end
            ST_DRDW:   st_next = ST_DRD;
            ST_DRD:    st_next = ST_DSTART;
            ST_DSTART: st_next = ST_DWAIT;
            ST_DWAIT:  if (drsp.done) st_next = last_comp ? ST_OUT : ST_DRDW;
            ST_NEW:    if (last_comp) st_next = ST_OUT;
            ST_OUT:    if (out_free) st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; md_reg <= smmt_pkg::MATCH_DIST_RST;
            sph_used_reg <= '0; cyl_used_reg <= '0; ovalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_we) md_reg <= cfg_wdata;
            if (st_reg == ST_OUT && out_free) ovalid_reg <= 1'b1;
            else if (m_ready) ovalid_reg <= 1'b0;
            if (st_reg == ST_IDLE && s_valid && s_frame_start) begin
                sph_used_reg <= '0; cyl_used_reg <= '0;
            end
            if (st_reg == ST_NEW && last_comp) begin
                if (cyl_reg) cyl_used_reg <= cyl_used_reg + UW'(1);
                else sph_used_reg <= sph_used_reg + UW'(1);
            end
        end
        unique case (st_reg)
            ST_IDLE: begin
                cyl_reg <= s_kind;
                m_reg[0] <= s_val0; m_reg[1] <= s_val1; m_reg[2] <= s_val2;
                m_reg[3] <= s_val3; m_reg[4] <= s_val4; m_reg[5] <= s_val5;
                m_reg[6] <= s_val6;
                for (int i = 0; i < smmt_pkg::CYL_COMP; i++) res_reg[i] <= '0;
            end
            ST_PREP: begin
                // Cylinder: center = base + floor(axis/2), saturated.
                if (cyl_reg) begin
                    for (int i = 0; i < 3; i++) begin
                        logic signed [32:0] c;
                        c = 33'(m_reg[i]) + 33'(m_reg[i+3] >>> 1);
                        m_reg[i] <= (c > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                                    (c < -33'sh0_8000_0000) ? 32'sh8000_0000 : c[31:0];
                    end
                end else begin
                    m_reg[4] <= '0; m_reg[5] <= '0; m_reg[6] <= '0;
                end
                ent_reg <= '0; var_reg <= 1'b0; comp_reg <= '0;
                acc_reg <= '0; far_reg <= 1'b0;
                new_reg <= 1'b0; full_reg <= 1'b0; slot_reg <= '0;
            end
            ST_ACC: begin
                if (ad[32] || ad[31]) far_reg <= 1'b1;
                acc_reg <= (acc_sum > 65'(smmt_pkg::DIST_SAT)) ? smmt_pkg::DIST_SAT
                                                                : acc_sum[63:0];
                comp_reg <= last_comp ? '0 : comp_reg + CW'(1);
            end
            ST_DEC: begin
                acc_reg <= '0; far_reg <= 1'b0; comp_reg <= '0;
                if (!far_reg && acc_reg < 64'(md_reg) * 64'(md_reg)) begin
                    n_reg <= n_inc; slot_reg <= 4'(ent_reg);
                end else if (cyl_reg && !var_reg) begin
                    var_reg <= 1'b1;
                end else if (UW'(ent_reg) + UW'(1) < used) begin
                    var_reg <= 1'b0; ent_reg <= ent_reg + IW'(1);
                end else if (used < UW'(MAX_ENTRIES)) begin
                    var_reg <= 1'b0; ent_reg <= IW'(used);
                end else begin
                    full_reg <= 1'b1; slot_reg <= '0;
                end
            end
            ST_DWAIT: if (drsp.done) begin
                res_reg[comp_reg] <= blended;
                comp_reg <= comp_reg + CW'(1);
            end
            ST_NEW: begin
                new_reg <= 1'b1; slot_reg <= 4'(ent_reg);
                res_reg[comp_reg] <= m_reg[comp_reg];
                comp_reg <= comp_reg + CW'(1);
            end
            ST_OUT: if (out_free) begin
                out_slot_reg <= slot_reg;
                out_new_reg <= new_reg;
                out_full_reg <= full_reg;
                for (int i = 0; i < smmt_pkg::CYL_COMP; i++) out_mean_reg[i] <= res_reg[i];
            end
            default: ;
        endcase
    end

    assign s_ready = (st_reg == ST_IDLE);
    assign m_valid = ovalid_reg;
    assign m_slot = out_slot_reg;
    assign m_is_new = out_new_reg;
    assign m_table_full = out_full_reg;
    assign m_mean0 = out_mean_reg[0];
    assign m_mean1 = out_mean_reg[1];
    assign m_mean2 = out_mean_reg[2];
    assign m_mean3 = out_mean_reg[3];
    assign m_mean4 = out_mean_reg[4];
    assign m_mean5 = out_mean_reg[5];
    assign m_mean6 = out_mean_reg[6];

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_IDLE) |-> !s_ready) else $error("ready while busy");
    a_full_not_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_table_full && m_is_new)) else $error("full and new");
    a_out_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_OUT) |=> m_valid) else $error("result lost");
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (sph_used_reg <= UW'(MAX_ENTRIES)) && (cyl_used_reg <= UW'(MAX_ENTRIES)))
        else $error("fill count overflow");
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the shape measurement merge table.
module tb_top;

    localparam int  LIMIT_CYCLES = 20000000;
    // Slowest request: full scan of two variants plus seven serial divides.
    localparam int  SETTLE       = 800;
    localparam longint ONE31     = 64'sh8000_0000;

    typedef struct packed {
        bit              kind;
        bit              frame_start;
        bit [6:0][31:0]  val;
    } shape_req_t;

    typedef struct packed {
        bit [3:0]        slot;
        bit              is_new;
        bit              table_full;
        bit [6:0][31:0]  mean;
    } merge_res_t;

    // Holds its own copy of both tables and the pending expected merges.
    class merge_scoreboard;
        longint     means [2][smmt_pkg::MAX_ENTRIES_DEF][smmt_pkg::CYL_COMP];
        int         counts[2][smmt_pkg::MAX_ENTRIES_DEF];
        int         used  [2];
        bit [30:0]  match_dist;
        merge_res_t pending_merges[$];
        int         fails;

        function new();
            match_dist = smmt_pkg::MATCH_DIST_RST;
            used[0] = 0;
            used[1] = 0;
            fails = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            fails++;
        endtask

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -ONE31) return -ONE31;
            return v;
        endfunction

        // Quotient rounded toward minus infinity, divisor always positive.
        function longint floor_div(longint num, longint den);
            longint q;
            q = num / den;
            if ((num % den) != 0 && num < 0) q--;
            return q;
        endfunction

        function bit near(int k, int j, longint m[smmt_pkg::CYL_COMP], int nc);
            longint unsigned acc, a, eps2;
            longint d;
            acc  = 0;
            eps2 = longint'(match_dist) * longint'(match_dist);
            for (int i = 0; i < nc; i++) begin
                d = m[i] - means[k][j][i];
                a = (d < 0) ? -d : d;
                if (a >= ONE31) return 0;
                acc += a * a;
                if (acc > 64'h4000_0000_0000_0000) acc = 64'h4000_0000_0000_0000;
            end
            return acc < eps2;
        endfunction

        // Accepted request: update the tables and queue the expected merge.
        function void note_request(shape_req_t r);
            longint     m[smmt_pkg::CYL_COMP], mm[smmt_pkg::CYL_COMP];
            longint     src[smmt_pkg::CYL_COMP];
            longint     ax, d;
            int         k, nc, slot, n;
            bit         hit, fresh, full;
            merge_res_t res;
            k = r.kind;
            nc = k ? smmt_pkg::CYL_COMP : smmt_pkg::SPH_COMP;
            hit = 0; fresh = 0; full = 0; slot = 0;
            if (r.frame_start) begin
                used[0] = 0;
                used[1] = 0;
            end
            for (int i = 0; i < smmt_pkg::CYL_COMP; i++) m[i] = 0;
            if (k == 0) begin
                for (int i = 0; i < smmt_pkg::SPH_COMP; i++)
                    m[i] = longint'($signed(r.val[i]));
            end else begin
                for (int i = 0; i < 3; i++) begin
                    ax = longint'($signed(r.val[3+i]));
                    m[i] = sat32(longint'($signed(r.val[i])) + floor_div(ax, 2));
                    m[3+i] = ax;
                end
                m[6] = longint'($signed(r.val[6]));
            end
            mm = m;
            for (int i = 3; i < 6; i++) mm[i] = sat32(-m[i]);
            // First entry wins; a cylinder tries its flipped axis second.
            for (int j = 0; j < used[k] && !hit; j++) begin
                if (near(k, j, m, nc)) begin
                    hit = 1; slot = j; src = m;
                end else if (k == 1 && near(k, j, mm, nc)) begin
                    hit = 1; slot = j; src = mm;
                end
            end
            if (hit) begin
                n = counts[k][slot];
                if (n < 65535) n++;
                counts[k][slot] = n;
                for (int i = 0; i < nc; i++) begin
                    d = src[i] - means[k][slot][i];
                    means[k][slot][i] += floor_div(2 * d + n, 2 * n);
                end
            end else if (used[k] < smmt_pkg::MAX_ENTRIES_DEF) begin
                slot = used[k];
                for (int i = 0; i < nc; i++) means[k][slot][i] = m[i];
                counts[k][slot] = 1;
                used[k] = slot + 1;
                hit = 1;
                fresh = 1;
            end else begin
                full = 1;
            end
            res.slot = slot[3:0];
            res.is_new = fresh;
            res.table_full = full;
            for (int i = 0; i < smmt_pkg::CYL_COMP; i++)
                res.mean[i] = (hit && i < nc) ? means[k][slot][i][31:0] : 32'd0;
            pending_merges.insert(pending_merges.size(), res);
        endfunction

        task check_result(merge_res_t got);
            merge_res_t want;
            if (pending_merges.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            want = pending_merges.pop_front();
            if (got.slot != want.slot)
                report($sformatf("slot got %0d exp %0d", got.slot, want.slot));
            if (got.is_new != want.is_new)
                report($sformatf("is_new got %0d exp %0d", got.is_new, want.is_new));
            if (got.table_full != want.table_full)
                report($sformatf("table_full got %0d exp %0d",
                                 got.table_full, want.table_full));
            for (int i = 0; i < smmt_pkg::CYL_COMP; i++)
                if (got.mean[i] != want.mean[i])
                    report($sformatf("mean%0d got %h exp %h", i,
                                     got.mean[i], want.mean[i]));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [30:0] cfg_wdata = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_kind = 0;
    logic        s_frame_start = 0;
    logic signed [31:0] s_val0 = 0, s_val1 = 0, s_val2 = 0, s_val3 = 0;
    logic signed [31:0] s_val4 = 0, s_val5 = 0, s_val6 = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [3:0]  m_slot;
    logic        m_is_new, m_table_full;
    logic signed [31:0] m_mean0, m_mean1, m_mean2, m_mean3, m_mean4, m_mean5, m_mean6;

    shape_measurement_merge_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_kind), .s_frame_start(s_frame_start),
        .s_val0(s_val0), .s_val1(s_val1), .s_val2(s_val2), .s_val3(s_val3),
        .s_val4(s_val4), .s_val5(s_val5), .s_val6(s_val6),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_slot(m_slot), .m_is_new(m_is_new), .m_table_full(m_table_full),
        .m_mean0(m_mean0), .m_mean1(m_mean1), .m_mean2(m_mean2), .m_mean3(m_mean3),
        .m_mean4(m_mean4), .m_mean5(m_mean5), .m_mean6(m_mean6)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    merge_scoreboard merges = new();
    int  cycle_count = 0;
    bit  no_idle = 0;       // both sides run back to back while set
    int  rx_hold = 0;       // one-shot long stall request for the receiver

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random backpressure, occasionally one long hold-off.
    initial begin
        int stall;
        merge_res_t got;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end
            repeat (stall) begin
                @(negedge aclk);
                m_ready = 0;
            end
            @(negedge aclk);
            m_ready = 1;
            do @(posedge aclk); while (!m_valid);
            got.slot = m_slot;
            got.is_new = m_is_new;
            got.table_full = m_table_full;
            got.mean = {m_mean6, m_mean5, m_mean4, m_mean3, m_mean2, m_mean1, m_mean0};
            merges.check_result(got);
        end
    end

    // Offer one request after a random gap; valid holds until accepted.
    task send_shape(shape_req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 0;
        end
        @(negedge aclk);
        s_kind = r.kind;
        s_frame_start = r.frame_start;
        {s_val6, s_val5, s_val4, s_val3, s_val2, s_val1, s_val0} = r.val;
        s_valid = 1;
        do @(posedge aclk); while (!s_ready);
        merges.note_request(r);
    endtask

    // Sender stops until every merge is back, then lets the block settle.
    task drain;
        @(negedge aclk);
        s_valid = 0;
        while (merges.pending_merges.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task write_distance(bit [30:0] new_dist);
        @(negedge aclk);
        cfg_we = 1;
        cfg_wdata = new_dist;
        @(negedge aclk);
        cfg_we = 0;
        merges.match_dist = new_dist;
    endtask

    function automatic bit [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -ONE31) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic shape_req_t make_sphere(bit fs, longint a, longint b,
                                               longint c, longint r);
        shape_req_t q;
        q.kind = 0;
        q.frame_start = fs;
        q.val = {$urandom(), $urandom(), $urandom(), clamp32(r), clamp32(c),
                 clamp32(b), clamp32(a)};
        return q;
    endfunction

    // Cylinder built from a center: base = center - floor(axis / 2).
    function automatic shape_req_t make_cyl(bit fs, longint cx, longint cy, longint cz,
                                            longint ax, longint ay, longint az,
                                            longint r);
        shape_req_t q;
        q.kind = 1;
        q.frame_start = fs;
        q.val = {clamp32(r), clamp32(az), clamp32(ay), clamp32(ax),
                 clamp32(cz - (az >>> 1)), clamp32(cy - (ay >>> 1)),
                 clamp32(cx - (ax >>> 1))};
        return q;
    endfunction

    function automatic longint jitter(longint amp);
        if (amp == 0) return 0;
        return longint'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    function automatic longint coord();
        if ($urandom_range(0, 9) == 0) return longint'($signed($urandom()));
        return longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    endfunction

    // Random phase: clusters around per-frame anchors, some noise requests.
    task random_phase(int count);
        longint anchor[$][7];
        longint a[7];
        longint amp, sgn;
        int     pick;
        bit     fs, cyl;
        shape_req_t q;
        amp = merges.match_dist / 4;
        if (amp > (1 << 24)) amp = 1 << 24;
        for (int n = 0; n < count; n++) begin
            fs = ($urandom_range(0, 39) == 0);
            if (fs) anchor.delete();
            if (n % 150 == 100) no_idle = ~no_idle;
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                q.kind = $urandom_range(0, 1);
                q.frame_start = fs;
                q.val = {$urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom()};
            end else begin
                if (anchor.size() == 0 || pick <= 2) begin
                    for (int i = 0; i < 7; i++) a[i] = coord();
                    a[0][62] = $urandom_range(0, 1);  // marks the kind of the cluster
                    anchor.insert(anchor.size(), a);
                end
                a = anchor[$urandom_range(0, anchor.size() - 1)];
                cyl = a[0][62];
                a[0][62] = a[0][63];
                if (!cyl)
                    q = make_sphere(fs, a[0] + jitter(amp), a[1] + jitter(amp),
                                    a[2] + jitter(amp), a[3] + jitter(amp));
                else begin
                    sgn = $urandom_range(0, 1) ? -1 : 1;
                    q = make_cyl(fs, a[0] + jitter(amp), a[1] + jitter(amp),
                                 a[2] + jitter(amp), sgn * a[3] + jitter(amp),
                                 sgn * a[4] + jitter(amp), sgn * a[5] + jitter(amp),
                                 a[6] + jitter(amp));
                end
            end
            send_shape(q);
            // Long receiver stall mid-phase while requests keep coming.
            if (n == 40) rx_hold = 3000;
        end
        no_idle = 0;
    endtask

    initial begin
        bit [30:0] dists[5];
        dists = '{31'd0, 31'd65536, 31'h7fff_ffff, 31'd1, 31'd2000000};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed requests at the reset distance.
        send_shape(make_sphere(1, 0, 0, 0, 0));
        send_shape(make_sphere(0, 0, 0, 0, 0));               // exact match
        send_shape(make_sphere(0, 100, 0, 0, 0));             // near match
        send_shape(make_sphere(0, 2147483647, 2147483647, 2147483647, 2147483647));
        send_shape(make_sphere(0, -ONE31, -ONE31, -ONE31, -ONE31));
        // Center saturating high and low; minimum axis negates to maximum.
        begin
            shape_req_t q;
            q.kind = 1; q.frame_start = 0;
            q.val = {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
            send_shape(q);
            q.val = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            send_shape(q);
            send_shape(q);
        end
        send_shape(make_cyl(0, 0, 0, 0, 1000, 2000, 3000, 500));
        send_shape(make_cyl(0, 0, 0, 0, -1000, -2000, -3000, 500));  // flipped axis
        send_shape(make_cyl(0, 10, 0, 0, -3, -5, 7, 500));           // odd negative axis
        send_shape(make_cyl(1, 0, 0, 0, 1000, 2000, 3000, 500));     // new frame
        send_shape(make_sphere(0, 0, 0, 0, 0));
        random_phase(300);
        drain;

        foreach (dists[p]) begin
            write_distance(dists[p]);
            random_phase(320);
            drain;
        end

        if (merges.fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
